@@ hdl/somr_pkg.sv @@
package somr_pkg;

    localparam int MAX_DIM_DEF = 64;
    localparam int DIM_LIM     = 64;
    localparam int COORD_W     = 6;
    localparam int CNT_W       = 7;
    localparam int VALUE_W     = 32;
    localparam int CMD_W       = 2;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_NEXT  = 2'd2
    } cmd_t;

    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    typedef struct packed {
        logic wr_en;
        logic start;
        logic step;
        logic load;
    } ctl_t;

endpackage

@@ hdl/somr_ram.sv @@
module somr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/somr_ctrl.sv @@
module somr_ctrl
    import somr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [CMD_W-1:0] cmd,
    output logic             m_tvalid,
    input  logic             m_tready,
    output ctl_t             ctl
);

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        ctl           = '0;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (cmd)
                        CMD_WRITE: ctl.wr_en = 1'b1;
                        CMD_START: ctl.start = 1'b1;
                        CMD_NEXT: begin
                            ctl.step   = 1'b1;
                            state_next = ST_FETCH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FETCH: begin
                ctl.load      = 1'b1;
                m_tvalid_next = 1'b1;
                state_next    = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_load_after_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load |-> $past(ctl.step))
        else $error("result load without a preceding fetch");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !ctl.load)
        else $error("pending result overwritten");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |-> !s_tready)
        else $error("request accepted during fetch");

    a_valid_from_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FETCH))
        else $error("result raised outside fetch");

endmodule

@@ hdl/somr_datapath.sv @@
module somr_datapath
    import somr_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ctl_t               ctl,
    input  logic               cfg_valid,
    input  logic               cfg_index,
    input  logic [CNT_W-1:0]   cfg_data,
    input  logic [COORD_W-1:0] row,
    input  logic [COORD_W-1:0] col,
    input  logic [VALUE_W-1:0] value,
    input  logic               anticlockwise,
    output logic [VALUE_W-1:0] elem_value,
    output logic [COORD_W-1:0] elem_row,
    output logic [COORD_W-1:0] elem_col,
    output logic               last,
    output logic               valid_res
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int LIM   = (MAX_DIM < DIM_LIM) ? MAX_DIM : DIM_LIM;

    typedef enum logic [1:0] {
        DIR_R = 2'd0,
        DIR_D = 2'd1,
        DIR_L = 2'd2,
        DIR_U = 2'd3
    } dir_t;

    function automatic logic [COORD_W-1:0] last_index(input logic [CNT_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v == '0) begin
            r = '0;
        end else if (v > CNT_W'(LIM)) begin
            r = COORD_W'(LIM - 1);
        end else begin
            r = COORD_W'(v - 1'b1);
        end
        return r;
    endfunction

    logic [CNT_W-1:0]   row_count_reg, col_count_reg;
    logic [COORD_W-1:0] top_reg, bottom_reg, left_reg, right_reg;
    logic [COORD_W-1:0] top_next, bottom_next, left_next, right_next;
    logic [COORD_W-1:0] cur_row_reg, cur_col_reg, cur_row_next, cur_col_next;
    dir_t               dir_reg, dir_next;
    logic               mode_reg, mode_next;
    logic               active_reg, active_next;
    logic               done;

    logic [VALUE_W-1:0] out_value_reg;
    logic [COORD_W-1:0] out_row_reg, out_col_reg;
    logic               out_last_reg, out_hit_reg;

    logic               wr_ok;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [VALUE_W-1:0] rd_data;

    assign wr_ok   = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
    assign wr_addr = AW'(row) * AW'(MAX_DIM) + AW'(col);
    assign rd_addr = AW'(cur_row_reg) * AW'(MAX_DIM) + AW'(cur_col_reg);

    somr_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (ctl.wr_en && wr_ok),
        .wr_addr(wr_addr),
        .wr_data(value),
        .rd_en  (ctl.step),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_comb begin
        top_next     = top_reg;
        bottom_next  = bottom_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        dir_next     = dir_reg;
        mode_next    = mode_reg;
        active_next  = active_reg;
        done         = 1'b0;
        if (!mode_reg) begin
            unique case (dir_reg)
                DIR_R: begin
                    if (cur_col_reg < right_reg) begin
                        cur_col_next = cur_col_reg + 1'b1;
                    end else if (top_reg >= bottom_reg) begin
                        done = 1'b1;
                    end else begin
                        top_next     = top_reg + 1'b1;
                        dir_next     = DIR_D;
                        cur_row_next = top_reg + 1'b1;
                        cur_col_next = right_reg;
                    end
                end
                DIR_D: begin
                    if (cur_row_reg < bottom_reg) begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end else if (left_reg >= right_reg) begin
                        done = 1'b1;
                    end else begin
                        right_next   = right_reg - 1'b1;
                        dir_next     = DIR_L;
                        cur_row_next = bottom_reg;
                        cur_col_next = right_reg - 1'b1;
                    end
                end
                DIR_L: begin
                    if (cur_col_reg > left_reg) begin
                        cur_col_next = cur_col_reg - 1'b1;
                    end else if (top_reg >= bottom_reg) begin
                        done = 1'b1;
                    end else begin
                        bottom_next  = bottom_reg - 1'b1;
                        dir_next     = DIR_U;
                        cur_row_next = bottom_reg - 1'b1;
                        cur_col_next = left_reg;
                    end
                end
                default: begin
                    if (cur_row_reg > top_reg) begin
                        cur_row_next = cur_row_reg - 1'b1;
                    end else if (left_reg >= right_reg) begin
                        done = 1'b1;
                    end else begin
                        left_next    = left_reg + 1'b1;
                        dir_next     = DIR_R;
                        cur_row_next = top_reg;
                        cur_col_next = left_reg + 1'b1;
                    end
                end
            endcase
        end else begin
            unique case (dir_reg)
                DIR_D: begin
                    if (cur_row_reg < bottom_reg) begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end else if (left_reg >= right_reg) begin
                        done = 1'b1;
                    end else begin
                        left_next    = left_reg + 1'b1;
                        dir_next     = DIR_R;
                        cur_row_next = bottom_reg;
                        cur_col_next = left_reg + 1'b1;
                    end
                end
                DIR_R: begin
                    if (cur_col_reg < right_reg) begin
                        cur_col_next = cur_col_reg + 1'b1;
                    end else if (top_reg >= bottom_reg) begin
                        done = 1'b1;
                    end else begin
                        bottom_next  = bottom_reg - 1'b1;
                        dir_next     = DIR_U;
                        cur_row_next = bottom_reg - 1'b1;
                        cur_col_next = right_reg;
                    end
                end
                DIR_U: begin
                    if (cur_row_reg > top_reg) begin
                        cur_row_next = cur_row_reg - 1'b1;
                    end else if (left_reg >= right_reg) begin
                        done = 1'b1;
                    end else begin
                        right_next   = right_reg - 1'b1;
                        dir_next     = DIR_L;
                        cur_row_next = top_reg;
                        cur_col_next = right_reg - 1'b1;
                    end
                end
                default: begin
                    if (cur_col_reg > left_reg) begin
                        cur_col_next = cur_col_reg - 1'b1;
                    end else if (top_reg >= bottom_reg) begin
                        done = 1'b1;
                    end else begin
                        top_next     = top_reg + 1'b1;
                        dir_next     = DIR_D;
                        cur_row_next = top_reg + 1'b1;
                        cur_col_next = left_reg;
                    end
                end
            endcase
        end
        if (done) begin
            active_next = 1'b0;
        end
        if (ctl.start) begin
            mode_next    = anticlockwise;
            top_next     = '0;
            left_next    = '0;
            bottom_next  = last_index(row_count_reg);
            right_next   = last_index(col_count_reg);
            cur_row_next = '0;
            cur_col_next = '0;
            dir_next     = anticlockwise ? DIR_D : DIR_R;
            active_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= CNT_W'(1);
            col_count_reg <= CNT_W'(1);
            top_reg       <= '0;
            bottom_reg    <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            dir_reg       <= DIR_R;
            mode_reg      <= 1'b0;
            active_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_ROW_COUNT: row_count_reg <= cfg_data;
                    REG_COL_COUNT: col_count_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (ctl.start || (ctl.step && active_reg)) begin
                top_reg     <= top_next;
                bottom_reg  <= bottom_next;
                left_reg    <= left_next;
                right_reg   <= right_next;
                cur_row_reg <= cur_row_next;
                cur_col_reg <= cur_col_next;
                dir_reg     <= dir_next;
                mode_reg    <= mode_next;
                active_reg  <= active_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.step) begin
            out_hit_reg  <= active_reg;
            out_row_reg  <= active_reg ? cur_row_reg : '0;
            out_col_reg  <= active_reg ? cur_col_reg : '0;
            out_last_reg <= active_reg && done;
        end
        if (ctl.load) begin
            out_value_reg <= out_hit_reg ? rd_data : '0;
        end
    end

    assign elem_value = out_value_reg;
    assign elem_row   = out_row_reg;
    assign elem_col   = out_col_reg;
    assign last       = out_last_reg;
    assign valid_res  = out_hit_reg;

endmodule

@@ hdl/spiral_order_matrix_reader_unit.sv @@
// Spiral-order matrix reader.
// Requests arrive on the s_ channel: tuser carries the command (write element,
// start traversal, fetch next), tdata the write position, value and order flag.
// Results leave on the m_ channel, one per fetch request: tdata holds value,
// row and column, tlast marks the final element, tuser is 1 when an element
// was returned and 0 when no traversal was active.
// Row and column counts are set on the cfg_ channel (index 0 rows, 1 columns)
// and take effect at the next start; cfg_ready is always high.
// Write and start requests are applied when accepted. A fetch reads the
// registered store read port, then loads the output register in the fetch
// state, and no request is taken meanwhile; the next request is taken in
// the cycle the result leaves.
// A result waiting in the output register blocks only new requests; once it
// is taken, s_tready returns in the same cycle.
// Reset clears the traversal and sets both counts to one; the matrix store
// keeps no reset and must be written before it is read.
module spiral_order_matrix_reader_unit
    import somr_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // row, col, value, anticlockwise
    input  logic [CMD_W-1:0]      s_tuser,   // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // elem_value, elem_row, elem_col
    output logic                  m_tlast,
    output logic                  m_tuser,   // valid_res
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CNT_W-1:0]      cfg_data
);

    ctl_t               ctl;
    logic [VALUE_W-1:0] elem_value;
    logic [COORD_W-1:0] elem_row, elem_col;

    assign cfg_ready = 1'b1;

    somr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .cmd     (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .ctl     (ctl)
    );

    somr_datapath #(
        .MAX_DIM(MAX_DIM)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .row          (s_tdata[5:0]),
        .col          (s_tdata[11:6]),
        .value        (s_tdata[43:12]),
        .anticlockwise(s_tdata[44]),
        .elem_value   (elem_value),
        .elem_row     (elem_row),
        .elem_col     (elem_col),
        .last         (m_tlast),
        .valid_res    (m_tuser)
    );

    assign m_tdata = {4'b0, elem_col, elem_row, elem_value};

endmodule

@@ tb/spiral_order_matrix_reader_unit_test.sv @@
module spiral_order_matrix_reader_unit_test;
    import somr_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int STORE_CELLS    = 4096;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int MAX_REPORTS    = 30;

    typedef enum logic [1:0] {GO_RIGHT, GO_DOWN, GO_LEFT, GO_UP} heading_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [VALUE_W-1:0] value;
        logic               anti;
    } request_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
        logic               found;
    } element_t;

    typedef struct packed {
        int       top;
        int       bottom;
        int       left;
        int       right;
        int       row;
        int       col;
        heading_t heading;
        logic     anti;
        logic     active;
    } walk_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [CMD_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = 1'b0;
    logic [CNT_W-1:0]      cfg_data = '0;

    spiral_order_matrix_reader_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    request_t           pending_reqs[$];
    element_t           elem_expected[$];
    request_t           live_req;
    logic [VALUE_W-1:0] elem_store [0:STORE_CELLS-1];
    bit                 cell_written [0:STORE_CELLS-1];
    logic [CNT_W-1:0]   rows_reg = 7'd1;
    logic [CNT_W-1:0]   cols_reg = 7'd1;
    walk_t              plan_walk;
    walk_t              live_walk;
    logic               idle_on = 1'b1;
    int                 send_gap = 0;
    int                 ready_hold = 0;
    int                 n_errors = 0;
    int                 n_requests = 0;
    int                 n_useful = 0;
    int                 n_elements = 0;
    int                 n_idle_fetches = 0;
    int                 n_spirals = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int gap_len();
        int pick;
        if (!idle_on) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int dim_of(input logic [CNT_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > DIM_LIM) return DIM_LIM;
        return int'(raw);
    endfunction

    function automatic walk_t walk_begin(input logic anti);
        walk_t w;
        w.top     = 0;
        w.left    = 0;
        w.bottom  = dim_of(rows_reg) - 1;
        w.right   = dim_of(cols_reg) - 1;
        w.row     = 0;
        w.col     = 0;
        w.heading = anti ? GO_DOWN : GO_RIGHT;
        w.anti    = anti;
        w.active  = 1'b1;
        return w;
    endfunction

    // Step to the next spiral position; shrink one bound at the end of each pass.
    task automatic walk_step(inout walk_t w, output logic done);
        done = 1'b0;
        if (!w.anti) begin
            case (w.heading)
                GO_RIGHT: if (w.col < w.right) w.col = w.col + 1;
                else begin
                    w.top = w.top + 1;
                    if (w.top > w.bottom) done = 1'b1;
                    else begin
                        w.heading = GO_DOWN; w.row = w.top; w.col = w.right;
                    end
                end
                GO_DOWN: if (w.row < w.bottom) w.row = w.row + 1;
                else begin
                    w.right = w.right - 1;
                    if (w.left > w.right) done = 1'b1;
                    else begin
                        w.heading = GO_LEFT; w.row = w.bottom; w.col = w.right;
                    end
                end
                GO_LEFT: if (w.col > w.left) w.col = w.col - 1;
                else begin
                    w.bottom = w.bottom - 1;
                    if (w.top > w.bottom) done = 1'b1;
                    else begin
                        w.heading = GO_UP; w.row = w.bottom; w.col = w.left;
                    end
                end
                default: if (w.row > w.top) w.row = w.row - 1;
                else begin
                    w.left = w.left + 1;
                    if (w.left > w.right) done = 1'b1;
                    else begin
                        w.heading = GO_RIGHT; w.row = w.top; w.col = w.left;
                    end
                end
            endcase
        end else begin
            case (w.heading)
                GO_DOWN: if (w.row < w.bottom) w.row = w.row + 1;
                else begin
                    w.left = w.left + 1;
                    if (w.left > w.right) done = 1'b1;
                    else begin
                        w.heading = GO_RIGHT; w.row = w.bottom; w.col = w.left;
                    end
                end
                GO_RIGHT: if (w.col < w.right) w.col = w.col + 1;
                else begin
                    w.bottom = w.bottom - 1;
                    if (w.top > w.bottom) done = 1'b1;
                    else begin
                        w.heading = GO_UP; w.row = w.bottom; w.col = w.right;
                    end
                end
                GO_UP: if (w.row > w.top) w.row = w.row - 1;
                else begin
                    w.right = w.right - 1;
                    if (w.left > w.right) done = 1'b1;
                    else begin
                        w.heading = GO_LEFT; w.row = w.top; w.col = w.right;
                    end
                end
                default: if (w.col > w.left) w.col = w.col - 1;
                else begin
                    w.top = w.top + 1;
                    if (w.top > w.bottom) done = 1'b1;
                    else begin
                        w.heading = GO_DOWN; w.row = w.top; w.col = w.left;
                    end
                end
            endcase
        end
        if (done) w.active = 1'b0;
    endtask

    task automatic predict_request(input request_t rq);
        element_t res;
        logic     done;
        case (rq.cmd)
            CMD_WRITE: elem_store[{rq.row, rq.col}] = rq.value;
            CMD_START: live_walk = walk_begin(rq.anti);
            CMD_NEXT: begin
                res = '0;
                if (live_walk.active) begin
                    res.row   = COORD_W'(live_walk.row);
                    res.col   = COORD_W'(live_walk.col);
                    res.value = elem_store[{res.row, res.col}];
                    walk_step(live_walk, done);
                    res.last  = done;
                    res.found = 1'b1;
                end
                elem_expected.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic check_element();
        element_t want;
        if (elem_expected.size() == 0) begin
            report_mismatch("element returned with no fetch request waiting");
        end else begin
            want = elem_expected.pop_front();
            if (m_tdata[VALUE_W-1:0] != want.value)
                report_mismatch($sformatf("elem_value %h, want %h",
                                          m_tdata[VALUE_W-1:0], want.value));
            if (m_tdata[VALUE_W+COORD_W-1:VALUE_W] != want.row)
                report_mismatch($sformatf("elem_row %0d, want %0d",
                                          m_tdata[VALUE_W+COORD_W-1:VALUE_W], want.row));
            if (m_tdata[VALUE_W+2*COORD_W-1:VALUE_W+COORD_W] != want.col)
                report_mismatch($sformatf("elem_col %0d, want %0d",
                                          m_tdata[VALUE_W+2*COORD_W-1:VALUE_W+COORD_W],
                                          want.col));
            if (m_tlast != want.last)
                report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
            if (m_tuser != want.found)
                report_mismatch($sformatf("valid_res %b, want %b", m_tuser, want.found));
            if (want.found) n_elements++;
            else n_idle_fetches++;
            if (want.found && want.last) n_spirals++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_request(live_req);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    live_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_DATA_W'({live_req.anti, live_req.value,
                                            live_req.col, live_req.row});
                    s_tuser  <= live_req.cmd;
                    send_gap = gap_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_element();
            if (ready_hold > 0) begin
                ready_hold = ready_hold - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ((m_tvalid && m_tready) || $urandom_range(0, 15) == 0)
                    ready_hold = gap_len();
            end
        end
    end

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic request_t rand_request(input logic [CMD_W-1:0] cmd);
        request_t rq;
        rq.cmd   = cmd;
        rq.row   = COORD_W'($urandom);
        rq.col   = COORD_W'($urandom);
        rq.value = rand_value();
        rq.anti  = 1'($urandom);
        return rq;
    endfunction

    // Queue a request; fill the cell a fetch is about to read if it was never written.
    task automatic push_request(input request_t rq);
        request_t fill;
        logic     done;
        case (rq.cmd)
            CMD_WRITE: cell_written[{rq.row, rq.col}] = 1'b1;
            CMD_START: plan_walk = walk_begin(rq.anti);
            CMD_NEXT: if (plan_walk.active) begin
                fill     = rand_request(CMD_WRITE);
                fill.row = COORD_W'(plan_walk.row);
                fill.col = COORD_W'(plan_walk.col);
                if (!cell_written[{fill.row, fill.col}]) begin
                    cell_written[{fill.row, fill.col}] = 1'b1;
                    pending_reqs.push_back(fill);
                    n_requests++;
                    n_useful++;
                end
                walk_step(plan_walk, done);
            end
            default: ;
        endcase
        pending_reqs.push_back(rq);
        n_requests++;
        if (rq.cmd != CMD_UNUSED) n_useful++;
    endtask

    task automatic run_spiral(input int fetches, input logic anti, input logic noisy);
        request_t rq;
        int       fetched;
        int       pick;
        rq = rand_request(CMD_START);
        rq.anti = anti;
        push_request(rq);
        fetched = 0;
        while (fetched < fetches) begin
            pick = noisy ? $urandom_range(0, 99) : 99;
            if (pick < 6) begin
                push_request(rand_request(CMD_WRITE));
            end else if (pick < 8) begin
                push_request(rand_request(CMD_UNUSED));
            end else if (pick < 10) begin
                push_request(rand_request(CMD_START));
            end else begin
                push_request(rand_request(CMD_NEXT));
                fetched++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_tvalid || elem_expected.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_count(input logic idx, input logic [CNT_W-1:0] raw);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= raw;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_ROW_COUNT) rows_reg = raw;
        else cols_reg = raw;
    endtask

    initial begin
        request_t         rq;
        logic [CNT_W-1:0] rr;
        logic [CNT_W-1:0] cc;
        int               total;
        int               fetches;
        logic             first_phase;

        plan_walk = '0;
        live_walk = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // 1 by 1 after reset: idle fetch, unused code, corner writes, both orders
        push_request(rand_request(CMD_NEXT));
        push_request(rand_request(CMD_UNUSED));
        rq = rand_request(CMD_WRITE);
        rq.row = '0; rq.col = '0; rq.value = '1;
        push_request(rq);
        rq.row = '1; rq.col = '1; rq.value = '0;
        push_request(rq);
        rq.row = '1; rq.col = '0; rq.value = 32'h8000_0000;
        push_request(rq);
        rq.row = '0; rq.col = '1; rq.value = 32'h7fff_ffff;
        push_request(rq);
        rq = rand_request(CMD_START);
        rq.anti = 1'b0;
        push_request(rq);
        push_request(rand_request(CMD_NEXT));
        push_request(rand_request(CMD_NEXT));
        rq.anti = 1'b1;
        push_request(rq);
        push_request(rand_request(CMD_NEXT));
        wait_drained();

        // 2 by 3: restart while active, overwrite an element ahead of the cursor
        write_count(REG_ROW_COUNT, 7'd2);
        write_count(REG_COL_COUNT, 7'd3);
        rq = rand_request(CMD_START);
        rq.anti = 1'b1;
        push_request(rq);
        push_request(rand_request(CMD_NEXT));
        push_request(rand_request(CMD_NEXT));
        rq.anti = 1'b0;
        push_request(rq);
        push_request(rand_request(CMD_NEXT));
        push_request(rand_request(CMD_NEXT));
        rq = rand_request(CMD_WRITE);
        rq.row = 6'd1; rq.col = 6'd1;
        push_request(rq);
        repeat (5) push_request(rand_request(CMD_NEXT));
        wait_drained();

        first_phase = 1'b1;
        while (n_useful < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    rr = CNT_W'($urandom_range(1, 6));
                    cc = CNT_W'($urandom_range(1, 6));
                end
                6: begin
                    rr = CNT_W'($urandom_range(1, 3));
                    cc = CNT_W'($urandom_range(7, 40));
                end
                7: begin
                    rr = CNT_W'($urandom_range(7, 40));
                    cc = CNT_W'($urandom_range(1, 3));
                end
                8: begin
                    rr = $urandom_range(0, 1) ? '0 : CNT_W'($urandom_range(65, 127));
                    cc = CNT_W'($urandom_range(1, 5));
                end
                default: begin
                    rr = CNT_W'($urandom_range(1, 5));
                    cc = $urandom_range(0, 1) ? '0 : CNT_W'($urandom_range(65, 127));
                end
            endcase
            if (first_phase || $urandom_range(0, 1)) write_count(REG_ROW_COUNT, rr);
            if (first_phase || $urandom_range(0, 1)) write_count(REG_COL_COUNT, cc);
            first_phase = 1'b0;
            idle_on = ($urandom_range(0, 3) != 0);
            total = dim_of(rows_reg) * dim_of(cols_reg);
            if ($urandom_range(0, 4) != 0) fetches = total + $urandom_range(0, 2);
            else fetches = $urandom_range(0, total);
            run_spiral(fetches, 1'($urandom), 1'($urandom));
            wait_drained();
        end

        // clamped counts: 64 rows by 3, 3 by 64 columns, then a single column and row
        idle_on = 1'b1;
        write_count(REG_ROW_COUNT, 7'd127);
        write_count(REG_COL_COUNT, 7'd3);
        run_spiral(3 * DIM_LIM, 1'b0, 1'b0);
        wait_drained();
        write_count(REG_ROW_COUNT, 7'd3);
        write_count(REG_COL_COUNT, 7'd65);
        run_spiral(3 * DIM_LIM, 1'b1, 1'b0);
        wait_drained();
        write_count(REG_ROW_COUNT, 7'd64);
        write_count(REG_COL_COUNT, 7'd0);
        run_spiral(DIM_LIM + 1, 1'b1, 1'b0);
        wait_drained();
        write_count(REG_ROW_COUNT, 7'd0);
        write_count(REG_COL_COUNT, 7'd64);
        run_spiral(DIM_LIM + 1, 1'b0, 1'b0);
        wait_drained();

        $display("%0d requests sent; %0d elements and %0d idle fetches checked",
                 n_requests, n_elements, n_idle_fetches);
        $display("%0d spirals run to the end, shapes from 1x1 up to 64 rows or columns",
                 n_spirals);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/somr_pkg.sv
hdl/somr_ram.sv
hdl/somr_ctrl.sv
hdl/somr_datapath.sv
hdl/spiral_order_matrix_reader_unit.sv
tb/spiral_order_matrix_reader_unit_test.sv
